/* src/rbs_pkg.sv */
package rbs_pkg;

  localparam int CmdW      = 2;
  localparam int FieldW    = 32;
  localparam int LimitW    = 31;
  localparam int InTdataW  = 232;
  localparam int OutTdataW = 8;
  localparam int FracBits  = 16;

  localparam logic [CmdW-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CmdW-1:0] CMD_ADD   = 2'd1;
  localparam logic [CmdW-1:0] CMD_TEST  = 2'd2;

endpackage

/* src/ray_box_slab_test_core.sv */
// Channel | Dir | Fields (low bit up)
// in_     | in  | tdata: cmd[1:0] origin_x origin_y origin_z dir_x dir_y dir_z t_limit[30:0], pad
// out_    | out | tdata: hit[0], pad
//
// Clear and add complete as the command is taken. A ray test runs one capture, one setup,
// the six bit-serial restoring dividers of COORD_BITS+16 quotient bits (33 in place of
// COORD_BITS above 32; one quotient bit per cycle), three reduce steps and one final step.
// rst_n is synchronous, active low; it empties the box and drops out_tvalid.
// A result held by out_tready low stalls the final step; input is taken only when idle.
module ray_box_slab_test_core
  import rbs_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // cmd, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_limit, zero pad
  input  logic [InTdataW-1:0]  in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // hit, zero pad
  output logic [OutTdataW-1:0] out_tdata
);

  localparam int CW   = (COORD_BITS > 32) ? 33 : COORD_BITS;
  localparam int QW   = CW + FracBits;
  localparam int CNTW = $clog2(QW + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_RED   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]             state_r;
  logic [CNTW-1:0]        cnt_r;
  logic signed [CW-1:0]   box_lo_r [3];
  logic signed [CW-1:0]   box_hi_r [3];
  logic                   empty_r;
  logic signed [CW-1:0]   org_r [3];
  logic signed [CW-1:0]   dir_r [3];
  logic [LimitW-1:0]      lim_r;
  logic [QW-1:0]          num_r [6];
  logic [CW-1:0]          rem_r [6];
  logic [CW-1:0]          dmag_r [6];
  logic                   qneg_r [6];
  logic [2:0]             fin_r;
  logic                   ins_r;
  logic signed [QW:0]     lo_r, hi_r;
  logic                   any_r;
  logic                   out_tvalid_r;
  logic                   hit_r;

  logic signed [CW-1:0]   in_c [6];
  logic [CmdW-1:0]        in_cmd;
  logic                   in_acc;
  logic signed [CW:0]     diff [6];
  logic [CW-1:0]          dmag_c [6];
  logic [CW:0]            trial [6];
  logic                   ge [6];
  logic signed [QW:0]     qv [6];
  logic [2:0]             ins_c;
  logic                   out_busy;
  logic signed [QW:0]     te, tx, lim_s;
  logic [1:0]             ax;

  assign in_cmd = in_tdata[CmdW-1:0];

  for (genvar i = 0; i < 6; i++) begin : g_fld
    if (COORD_BITS > 32) begin : g_wide
      assign in_c[i] = {1'b0, in_tdata[CmdW+FieldW*i +: FieldW]};
    end else begin : g_narrow
      assign in_c[i] = in_tdata[CmdW+FieldW*i +: CW];
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_busy   = out_tvalid_r && !out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OutTdataW-1){1'b0}}, hit_r};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      // entry lane 2a, exit lane 2a+1; bounds swap on negative direction
      diff[2*a]   = dir_r[a][CW-1] ? (CW+1)'(box_hi_r[a]) - (CW+1)'(org_r[a])
                                   : (CW+1)'(box_lo_r[a]) - (CW+1)'(org_r[a]);
      diff[2*a+1] = dir_r[a][CW-1] ? (CW+1)'(box_lo_r[a]) - (CW+1)'(org_r[a])
                                   : (CW+1)'(box_hi_r[a]) - (CW+1)'(org_r[a]);
      dmag_c[2*a]   = dir_r[a][CW-1] ? CW'(-(CW+1)'(dir_r[a])) : CW'(dir_r[a]);
      dmag_c[2*a+1] = dmag_c[2*a];
      ins_c[a] = (dir_r[a] != '0) || (org_r[a] >= box_lo_r[a] && org_r[a] <= box_hi_r[a]);
    end
    for (int l = 0; l < 6; l++) begin
      trial[l] = {rem_r[l], num_r[l][QW-1]};
      ge[l]    = trial[l] >= {1'b0, dmag_r[l]};
      qv[l]    = qneg_r[l] ? -$signed({1'b0, num_r[l]}) : $signed({1'b0, num_r[l]});
    end
    ax    = cnt_r[1:0];
    te    = qv[{ax, 1'b0}];
    tx    = qv[{ax, 1'b1}];
    lim_s = $signed({{(QW+1-LimitW){1'b0}}, lim_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      empty_r      <= 1'b1;
      out_tvalid_r <= 1'b0;
      cnt_r        <= '0;
      for (int a = 0; a < 3; a++) begin
        box_lo_r[a] <= '0;
        box_hi_r[a] <= '0;
      end
    end else begin
      // the final step drives out_tvalid itself
      if (out_tvalid_r && out_tready && state_r != ST_FIN) out_tvalid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_cmd)
              CMD_CLEAR: empty_r <= 1'b1;
              CMD_ADD: begin
                for (int a = 0; a < 3; a++) begin
                  if (empty_r || in_c[a] < box_lo_r[a]) box_lo_r[a] <= in_c[a];
                  if (empty_r || in_c[a] > box_hi_r[a]) box_hi_r[a] <= in_c[a];
                end
                empty_r <= 1'b0;
              end
              CMD_TEST: begin
                for (int a = 0; a < 3; a++) begin
                  org_r[a] <= in_c[a];
                  dir_r[a] <= in_c[a+3];
                end
                lim_r   <= in_tdata[CmdW+FieldW*6 +: LimitW];
                state_r <= ST_SETUP;
              end
              default: ;
            endcase
          end
        end
        ST_SETUP: begin
          for (int l = 0; l < 6; l++) begin
            num_r[l]  <= {(diff[l][CW] ? CW'(-diff[l]) : diff[l][CW-1:0]),
                          {FracBits{1'b0}}};
            rem_r[l]  <= '0;
            dmag_r[l] <= dmag_c[l];
            qneg_r[l] <= diff[l][CW] ^ dir_r[l/2][CW-1];
          end
          for (int a = 0; a < 3; a++) fin_r[a] <= (dir_r[a] != '0);
          ins_r   <= &ins_c;
          any_r   <= 1'b0;
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          for (int l = 0; l < 6; l++) begin
            rem_r[l] <= ge[l] ? CW'(trial[l] - {1'b0, dmag_r[l]}) : trial[l][CW-1:0];
            num_r[l] <= {num_r[l][QW-2:0], ge[l]};
          end
          if (cnt_r == CNTW'(QW - 1)) begin
            cnt_r   <= '0;
            state_r <= ST_RED;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_RED: begin
          if (fin_r[ax]) begin
            if (!any_r || te > lo_r) lo_r <= te;
            if (!any_r || tx < hi_r) hi_r <= tx;
            any_r <= 1'b1;
          end
          if (ax == 2'd2) state_r <= ST_FIN;
          else cnt_r <= cnt_r + 1'b1;
        end
        ST_FIN: begin
          if (!out_busy) begin
            hit_r        <= !empty_r && ins_r &&
                            (!any_r || (lo_r <= hi_r && lo_r < lim_s && hi_r > 0));
            out_tvalid_r <= 1'b1;
            cnt_r        <= '0;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_test_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_cmd == CMD_TEST |=> state_r == ST_SETUP)
    else $error("test command did not start setup");

  a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && !out_busy |=> out_tvalid_r && state_r == ST_IDLE)
    else $error("final step did not present a result");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV && dmag_r[0] != '0 |-> rem_r[0] < dmag_r[0])
    else $error("divider remainder out of range");

endmodule
